// ===== rtl/core/fcc_pkg.sv =====
// Shared types, constants and helpers for the frustum cull classifier.
// Used by the plane bank, the plane cells and the top level; depends on nothing.
package fcc_pkg;

  // Number of plane cells in the chain and of plane registers on the port.
  localparam int PLANE_COUNT = 6;
  localparam int REG_COUNT   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int PLANE_W     = 64;

  // Test kinds; the unused code falls back to the point test.
  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_BOX    = 2'd2;

  // Result codes.
  localparam logic [1:0] POS_FRONT = 2'd0;
  localparam logic [1:0] POS_BACK  = 2'd1;
  localparam logic [1:0] POS_SPAN  = 2'd2;

  typedef logic [PLANE_W-1:0] plane_word_t;

  // One object as it travels down the chain.
  typedef struct packed {
    logic [1:0]            mode;
    logic signed [15:0]    cx;
    logic signed [15:0]    cy;
    logic signed [15:0]    cz;
    logic [14:0]           radius;
    logic [2:0][47:0]      axis;
    logic [2:0][14:0]      extent;
  } fcc_item_t;

  // Control that travels with each object.
  typedef struct packed {
    logic       valid;
    logic       done;
    logic [1:0] pos;
  } fcc_stat_t;

  // Picks one signed 16-bit lane out of a packed word, lane 0 lowest.
  function automatic logic signed [15:0] lane16(input logic [63:0] w, input logic [1:0] k);
    return w[16*k +: 16];
  endfunction

endpackage

// ===== rtl/core/fcc_plane_bank.sv =====
// Plane register bank of the frustum cull classifier.
// Depends on fcc_pkg; feeds one plane word to each cell of the chain.
module fcc_plane_bank (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcc_pkg::PLANE_W-1:0]     cfg_data,
  output fcc_pkg::plane_word_t            planes [fcc_pkg::PLANE_COUNT]
);
  import fcc_pkg::*;

  plane_word_t store [REG_COUNT];

  // Writes to an index past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        store[i] <= '0;
      end
    end else if (cfg_write && (32'(cfg_index) < REG_COUNT)) begin
      store[cfg_index] <= cfg_data;
    end
  end

  // Cells beyond the register list see an all-zero plane.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    if (p < REG_COUNT) begin : g_reg
      assign planes[p] = store[p];
    end else begin : g_zero
      assign planes[p] = '0;
    end
  end

endmodule

// ===== rtl/core/fcc_cell.sv =====
// One plane cell of the frustum cull classifier: tests an object against one
// plane over four registered steps and hands it on. Depends on fcc_pkg.
module fcc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  fcc_pkg::plane_word_t plane,
  input  fcc_pkg::fcc_item_t   item_in,
  input  fcc_pkg::fcc_stat_t   stat_in,
  output fcc_pkg::fcc_item_t   item_out,
  output fcc_pkg::fcc_stat_t   stat_out
);
  import fcc_pkg::*;

  // Step registers.
  fcc_item_t          s1_item, s2_item, s3_item;
  fcc_stat_t          s1_stat, s2_stat, s3_stat;
  logic signed [31:0] s1_prod_c [3];
  logic signed [31:0] s1_prod_a [3][3];
  logic signed [15:0] s1_d;
  logic signed [33:0] s2_dist, s3_dist;
  logic [31:0]        s2_absdot [3];
  logic [46:0]        s3_ext_prod [3];

  // Combinational values of each step.
  logic signed [31:0] prod_c [3];
  logic signed [31:0] prod_a [3][3];
  logic signed [33:0] sdist;
  logic signed [32:0] dot [3];
  logic [31:0]        absdot [3];
  logic [46:0]        ext_prod [3];
  logic [48:0]        reach;
  logic [32:0]        abs_dist;
  logic [48:0]        abs_dist36;
  logic signed [34:0] rad_sh;
  logic signed [34:0] sphere_sum;
  logic               span;
  fcc_stat_t          stat_next;

  // Step one: centre and axis products against the plane normal.
  always_comb begin
    logic signed [31:0] nrm, cen, ax;
    for (int j = 0; j < 3; j++) begin
      nrm = lane16(plane, 2'(j));
      case (j)
        0:       cen = item_in.cx;
        1:       cen = item_in.cy;
        default: cen = item_in.cz;
      endcase
      prod_c[j] = nrm * cen;
      for (int k = 0; k < 3; k++) begin
        ax = lane16({16'd0, item_in.axis[k]}, 2'(j));
        prod_a[k][j] = nrm * ax;
      end
    end
  end

  // Step two: signed centre distance and absolute axis projections.
  always_comb begin
    sdist = 34'(s1_prod_c[0]) + 34'(s1_prod_c[1]) + 34'(s1_prod_c[2]) + (34'(s1_d) <<< 14);
    for (int k = 0; k < 3; k++) begin
      dot[k] = 33'(s1_prod_a[k][0]) + 33'(s1_prod_a[k][1]) + 33'(s1_prod_a[k][2]);
      absdot[k] = dot[k][32] ? 32'(-dot[k]) : 32'(dot[k]);
    end
  end

  // Step three: scale each projection by its half-extent.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext_prod[k] = 47'(s2_item.extent[k]) * 47'(s2_absdot[k]);
    end
  end

  // Step four: projected reach, comparisons and the decision for this plane.
  always_comb begin
    reach      = 49'(s3_ext_prod[0]) + 49'(s3_ext_prod[1]) + 49'(s3_ext_prod[2]);
    abs_dist   = s3_dist[33] ? 33'(-s3_dist) : 33'(s3_dist);
    abs_dist36 = {2'd0, abs_dist, 14'd0};
    span       = abs_dist36 < reach;
    rad_sh     = 35'({s3_item.radius, 14'd0});
    sphere_sum = 35'(s3_dist) + rad_sh;
    stat_next  = s3_stat;
    if (s3_stat.valid && !s3_stat.done) begin
      case (s3_item.mode)
        MODE_SPHERE: begin
          if (sphere_sum <= 35'sd0) begin
            stat_next.done = 1'b1;
            stat_next.pos  = POS_BACK;
          end
        end
        MODE_BOX: begin
          if (span) begin
            stat_next.done = 1'b1;
            stat_next.pos  = POS_SPAN;
          end else if (s3_dist[33]) begin
            stat_next.done = 1'b1;
            stat_next.pos  = POS_BACK;
          end
        end
        default: begin
          if (s3_dist[33]) begin
            stat_next.done = 1'b1;
            stat_next.pos  = POS_BACK;
          end
        end
      endcase
    end
  end

  // Control registers of the four steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_stat  <= '0;
      s2_stat  <= '0;
      s3_stat  <= '0;
      stat_out <= '0;
    end else if (adv) begin
      s1_stat  <= stat_in;
      s2_stat  <= s1_stat;
      s3_stat  <= s2_stat;
      stat_out <= stat_next;
    end
  end

  // Payload registers of the four steps.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item     <= item_in;
      s1_prod_c   <= prod_c;
      s1_prod_a   <= prod_a;
      s1_d        <= lane16(plane, 2'd3);
      s2_item     <= s1_item;
      s2_dist     <= sdist;
      s2_absdot   <= absdot;
      s3_item     <= s2_item;
      s3_dist     <= s2_dist;
      s3_ext_prod <= ext_prod;
      item_out    <= s3_item;
    end
  end

endmodule

// ===== rtl/core/frustum_cull_classifier.sv =====
// Frustum cull classifier: takes one object word per cycle unless the output
// stalls, and returns in front, behind or spanning. Each object passes through
// the chain of plane cells, each of which spends four registered steps on its
// plane (products, sums, extent scaling, decision). The last cell's register
// is the output register; while its word waits, the whole chain holds and no
// object is taken.
// Plane registers are written through the plain write port.
module frustum_cull_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcc_pkg::PLANE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      mode,
  input  logic signed [15:0]              centre_x,
  input  logic signed [15:0]              centre_y,
  input  logic signed [15:0]              centre_z,
  input  logic [14:0]                     radius,
  input  logic [47:0]                     axis_first,
  input  logic [47:0]                     axis_second,
  input  logic [47:0]                     axis_third,
  input  logic [14:0]                     extent_first,
  input  logic [14:0]                     extent_second,
  input  logic [14:0]                     extent_third,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      position
);
  import fcc_pkg::*;

  plane_word_t planes [PLANE_COUNT];
  fcc_item_t   item_c [PLANE_COUNT+1];
  fcc_stat_t   stat_c [PLANE_COUNT+1];
  logic        adv;

  // The chain moves whenever the output register is empty or being taken.
  assign adv       = !stat_c[PLANE_COUNT].valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = stat_c[PLANE_COUNT].valid;
  assign position  = stat_c[PLANE_COUNT].pos;

  // Incoming word enters the first cell undecided and in front.
  always_comb begin
    item_c[0].mode      = mode;
    item_c[0].cx        = centre_x;
    item_c[0].cy        = centre_y;
    item_c[0].cz        = centre_z;
    item_c[0].radius    = radius;
    item_c[0].axis[0]   = axis_first;
    item_c[0].axis[1]   = axis_second;
    item_c[0].axis[2]   = axis_third;
    item_c[0].extent[0] = extent_first;
    item_c[0].extent[1] = extent_second;
    item_c[0].extent[2] = extent_third;
    stat_c[0].valid     = in_valid;
    stat_c[0].done      = 1'b0;
    stat_c[0].pos       = POS_FRONT;
  end

  fcc_plane_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // One cell per plane, in test order.
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    fcc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .plane    (planes[p]),
      .item_in  (item_c[p]),
      .stat_in  (stat_c[p]),
      .item_out (item_c[p+1]),
      .stat_out (stat_c[p+1])
    );
  end

endmodule

// ===== rtl/core/fcc_checker.sv =====
// Port-level checks for the frustum cull classifier, bound to the top level.
// Depends only on the top level's ports.
module fcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] position
);

  // A waiting result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position))
    else $error("result word changed while stalled");

  // Only the three result codes ever appear.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position != 2'd3)
    else $error("unused result code");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // Input is taken exactly when the output side is free or draining.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind frustum_cull_classifier fcc_checker u_fcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .position  (position)
);
